// ===== rtl/hbd_pkg.sv =====
// package for the half-band decimator with level follower
// shared constants, register indexes and the queue status type; no dependencies
package hbd_pkg;

   localparam int DEF_TAPS        = 19;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int FIELD_BITS = 16;
   localparam int WEIGHT_BITS = 18;
   localparam int RATE_BITS   = 16;
   localparam int OUT_BITS    = 18;
   localparam int LEVEL_BITS  = 32;
   localparam int MAX_PAIRS   = 5;
   localparam int FRAC_SHIFT  = 17;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 18;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_CENTER  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_ATTACK  = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_RELEASE = 3'd7;

   localparam logic signed [WEIGHT_BITS-1:0] CENTER_RESET  = 18'sd65536;
   localparam logic [RATE_BITS-1:0]          ATTACK_RESET  = 16'd655;
   localparam logic [RATE_BITS-1:0]          RELEASE_RESET = 16'd7;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== rtl/hbd_front.sv =====
// front end: accepts samples, resizes them and tags each with its pair phase
// depends on hbd_pkg
module hbd_front import hbd_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [2*FIELD_BITS-1:0]       req_tdata,
   input  qstat_type                     q_stat,
   output logic                          q_push,
   output logic [2*SAMPLE_BITS:0]        q_wdata
);

   logic phase_ff, phase_in;
   logic signed [FIELD_BITS-1:0]  raw_i, raw_q;
   logic signed [SAMPLE_BITS-1:0] si, sq;

   // take low bits or sign extend to the working width
   assign raw_i = signed'(req_tdata[FIELD_BITS-1:0]);
   assign raw_q = signed'(req_tdata[2*FIELD_BITS-1:FIELD_BITS]);
   assign si    = SAMPLE_BITS'(raw_i);
   assign sq    = SAMPLE_BITS'(raw_q);

   assign req_tready = !q_stat.full;
   assign q_push     = req_tvalid && req_tready;
   assign q_wdata    = {phase_ff, sq, si};

   // pair phase toggles on every transaction
   assign phase_in = q_push ? !phase_ff : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== rtl/hbd_queue.sv =====
// two-entry queue between front and back end
// depends on hbd_pkg
module hbd_queue import hbd_pkg::*; #(
   parameter int WIDTH = 2*DEF_SAMPLE_BITS+1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output qstat_type        stat
);

   logic [WIDTH-1:0] mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == 2'd2);
   assign stat.empty = (cnt_ff == 2'd0);
   assign rdata      = mem_ff[rd_ff];

   assign wr_in  = push ? !wr_ff : wr_ff;
   assign rd_in  = pop ? !rd_ff : rd_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/hbd_back.sv =====
// back end: delay lines, shared multiply-accumulate, level follower, output register
// depends on hbd_pkg
module hbd_back import hbd_pkg::*; #(
   parameter int TAPS        = DEF_TAPS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_IDX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata,
   input  qstat_type                  q_stat,
   input  logic [2*SAMPLE_BITS:0]     q_rdata,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [71:0]                rsp_tdata
);

   localparam int SB     = SAMPLE_BITS;
   localparam int NP_RAW = (TAPS + 1) / 4;
   localparam int NP     = (NP_RAW > MAX_PAIRS) ? MAX_PAIRS : NP_RAW;
   localparam int SW     = $clog2(NP + 1);
   localparam int PSW    = SB + 1;
   localparam int PRW    = PSW + WEIGHT_BITS;
   localparam int ACC_W  = PRW + 3;
   localparam int PW_RAW = 2 * SB + 1;
   localparam int PW     = (PW_RAW > LEVEL_BITS + 1) ? PW_RAW : LEVEL_BITS + 1;
   localparam logic [SW-1:0] LAST_STEP = SW'(NP);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(131071);
   localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(131072);
   localparam logic [PW-1:0] PWR_MAX = PW'(33'h0_FFFF_FFFF);

   typedef enum logic [2:0] {
      S_IDLE, S_MAC, S_DRAIN, S_EMIT, S_SQR, S_DIFF, S_LVL
   } state_type;

   state_type state_ff;
   logic signed [WEIGHT_BITS-1:0] wt_ff [MAX_PAIRS+1];
   logic [RATE_BITS-1:0] attack_ff, release_ff;
   logic signed [SB-1:0] line_i_ff [TAPS];
   logic signed [SB-1:0] line_q_ff [TAPS];
   logic [SW-1:0] step_ff;
   logic signed [PRW-1:0] prod_i_ff, prod_q_ff;
   logic signed [ACC_W-1:0] acc_i_ff, acc_q_ff;
   logic [2*SB-1:0] sqr_i_ff, sqr_q_ff;
   logic [LEVEL_BITS-1:0] pwr_ff, level_ff, diff_ff;
   logic gt_ff;
   logic [LEVEL_BITS+RATE_BITS-1:0] lprod_ff;
   logic rsp_valid_ff;
   logic [OUT_BITS-1:0] out_i_ff, out_q_ff;
   logic [LEVEL_BITS-1:0] out_lvl_ff;
   logic lvl_pend_ff;

   logic signed [PSW-1:0] psum_i [NP+1];
   logic signed [PSW-1:0] psum_q [NP+1];
   logic signed [WEIGHT_BITS-1:0] cw [NP+1];
   logic signed [SB-1:0] new_i, new_q;
   logic new_phase;
   logic signed [2*SB-1:0] sq_i_full, sq_q_full;
   logic [PW-1:0] pwr_sum;
   logic signed [ACC_W-1:0] sh_i, sh_q;
   logic [OUT_BITS-1:0] sat_i, sat_q;
   logic emit_ok;
   logic [LEVEL_BITS-1:0] level_next;

   assign new_i     = signed'(q_rdata[SB-1:0]);
   assign new_q     = signed'(q_rdata[2*SB-1:SB]);
   assign new_phase = q_rdata[2*SB];
   assign q_pop     = (state_ff == S_IDLE) && !q_stat.empty;
   assign emit_ok   = !rsp_valid_ff || rsp_tready;

   // pair sums and weights at fixed taps, center in the last slot
   always_comb begin
      for (int c = 0; c < NP; c++) begin
         psum_i[c] = PSW'(line_i_ff[2*c]) + PSW'(line_i_ff[TAPS-1-2*c]);
         psum_q[c] = PSW'(line_q_ff[2*c]) + PSW'(line_q_ff[TAPS-1-2*c]);
         cw[c]     = wt_ff[c];
      end
      psum_i[NP] = PSW'(line_i_ff[(TAPS-1)/2]);
      psum_q[NP] = PSW'(line_q_ff[(TAPS-1)/2]);
      cw[NP]     = wt_ff[MAX_PAIRS];
   end

   // power of the sample and shifted accumulators
   assign sq_i_full = new_i * new_i;
   assign sq_q_full = new_q * new_q;
   assign pwr_sum   = PW'(sqr_i_ff) + PW'(sqr_q_ff);
   assign sh_i      = acc_i_ff >>> FRAC_SHIFT;
   assign sh_q      = acc_q_ff >>> FRAC_SHIFT;

   // saturation to the output range
   always_comb begin
      if (sh_i > SAT_HI) sat_i = SAT_HI[OUT_BITS-1:0];
      else if (sh_i < SAT_LO) sat_i = SAT_LO[OUT_BITS-1:0];
      else sat_i = sh_i[OUT_BITS-1:0];
      if (sh_q > SAT_HI) sat_q = SAT_HI[OUT_BITS-1:0];
      else if (sh_q < SAT_LO) sat_q = SAT_LO[OUT_BITS-1:0];
      else sat_q = sh_q[OUT_BITS-1:0];
   end

   // level after the pending rate product
   assign level_next = gt_ff ? level_ff + lprod_ff[LEVEL_BITS+RATE_BITS-1:RATE_BITS]
                             : level_ff - lprod_ff[LEVEL_BITS+RATE_BITS-1:RATE_BITS];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_PAIRS; k++) wt_ff[k] <= '0;
         wt_ff[MAX_PAIRS] <= CENTER_RESET;
         attack_ff        <= ATTACK_RESET;
         release_ff       <= RELEASE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_ATTACK:  attack_ff  <= csr_wdata[RATE_BITS-1:0];
            REG_RELEASE: release_ff <= csr_wdata[RATE_BITS-1:0];
            default:     wt_ff[csr_index] <= signed'(csr_wdata);
         endcase
      end
   end

   // sequencer, delay lines and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         step_ff      <= '0;
         for (int k = 0; k < TAPS; k++) begin
            line_i_ff[k] <= '0;
            line_q_ff[k] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_tready && !(state_ff == S_EMIT)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  line_i_ff[0] <= new_i;
                  line_q_ff[0] <= new_q;
                  for (int k = 1; k < TAPS; k++) begin
                     line_i_ff[k] <= line_i_ff[k-1];
                     line_q_ff[k] <= line_q_ff[k-1];
                  end
                  sqr_i_ff  <= sq_i_full;
                  sqr_q_ff  <= sq_q_full;
                  acc_i_ff  <= '0;
                  acc_q_ff  <= '0;
                  prod_i_ff <= '0;
                  prod_q_ff <= '0;
                  step_ff   <= '0;
                  state_ff  <= new_phase ? S_SQR : S_MAC;
               end
            end
            S_MAC: begin
               prod_i_ff <= psum_i[step_ff] * cw[step_ff];
               prod_q_ff <= psum_q[step_ff] * cw[step_ff];
               acc_i_ff  <= acc_i_ff + ACC_W'(prod_i_ff);
               acc_q_ff  <= acc_q_ff + ACC_W'(prod_q_ff);
               step_ff   <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) state_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               acc_i_ff <= acc_i_ff + ACC_W'(prod_i_ff);
               acc_q_ff <= acc_q_ff + ACC_W'(prod_q_ff);
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               // output register is free or drains this cycle
               if (emit_ok) begin
                  rsp_valid_ff <= 1'b1;
                  out_i_ff     <= sat_i;
                  out_q_ff     <= sat_q;
                  out_lvl_ff   <= level_ff;
                  state_ff     <= S_IDLE;
               end else if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_SQR: begin
               pwr_ff   <= (pwr_sum > PWR_MAX) ? '1 : pwr_sum[LEVEL_BITS-1:0];
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               gt_ff    <= pwr_ff > level_ff;
               diff_ff  <= (pwr_ff > level_ff) ? pwr_ff - level_ff : level_ff - pwr_ff;
               state_ff <= S_LVL;
            end
            S_LVL: begin
               // multiply here, apply next cycle
               lprod_ff <= diff_ff * (gt_ff ? attack_ff : release_ff);
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         // apply the level update in the cycle after the rate product
         if (lvl_pend_ff) level_ff <= level_next;
      end
   end

   // level update lands in the cycle after the rate product
   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_pend_ff <= 1'b0;
      end else begin
         lvl_pend_ff <= (state_ff == S_LVL);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, out_lvl_ff, out_q_ff, out_i_ff};

endmodule

// ===== rtl/halfband_decimator_with_level.sv =====
// half-band decimator by two with power level follower, top level
// occupancy: a first-of-pair sample holds the back end through the shared MAC steps, the
// drain and the emit, which waits while the output is held; a second-of-pair sample holds
// it through the square, difference and rate product; queue depth two
// reset: synchronous active high, clears delay lines, phase, level, queue and configuration registers
module halfband_decimator_with_level import hbd_pkg::*; #(
   parameter int TAPS        = DEF_TAPS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // sample_i [15:0], sample_q [31:16]
   input  logic [31:0]              req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // out_i [17:0], out_q [35:18], signal_level [67:36], zero fill [71:68]
   output logic [71:0]              rsp_tdata
);

   localparam int QW = 2 * SAMPLE_BITS + 1;

   qstat_type q_stat;
   logic q_push, q_pop;
   logic [QW-1:0] q_wdata, q_rdata;

   hbd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .q_stat, .q_push, .q_wdata
   );

   hbd_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset, .push(q_push), .wdata(q_wdata), .pop(q_pop),
      .rdata(q_rdata), .stat(q_stat)
   );

   hbd_back #(.TAPS(TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .q_stat, .q_rdata, .q_pop, .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty) else $error("queue underflow");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> req_tready) else $error("front stalled with empty queue");
`endif

endmodule
